// File: rtl/siphash_keyed_hash_assert.svh
// Assertion macros shared by the checkers of the keyed SipHash block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SIPHASH_KEYED_HASH_ASSERT_SVH
`define SIPHASH_KEYED_HASH_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SHK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SHK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/shk_pkg.sv
// Shared types, constants, the microcode table and the SipRound function.
// No dependencies; the top level, the sequencer, the datapath and the testbench files import this package.
`timescale 1ns / 1ps

package shk_pkg;

    // Initialization constants of the four lanes.
    localparam logic [63:0] INIT_A = 64'h736F6D6570736575;
    localparam logic [63:0] INIT_B = 64'h646F72616E646F6D;
    localparam logic [63:0] INIT_C = 64'h6C7967656E657261;
    localparam logic [63:0] INIT_D = 64'h7465646279746573;
    localparam logic [7:0]  FIN_XOR = 8'hFF;

    // Rotation amounts of one SipRound.
    localparam int unsigned ROT_B1 = 13;
    localparam int unsigned ROT_A  = 32;
    localparam int unsigned ROT_D1 = 16;
    localparam int unsigned ROT_D2 = 21;
    localparam int unsigned ROT_B2 = 17;

    localparam logic [3:0] BYTES_PER_WORD = 4'd8;
    localparam logic [3:0] RESET_COMP_ROUNDS  = 4'd2;
    localparam logic [3:0] RESET_FINAL_ROUNDS = 4'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY_LOW      = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH     = 2'd1;
    localparam logic [1:0] CFG_COMP_ROUNDS  = 2'd2;
    localparam logic [1:0] CFG_FINAL_ROUNDS = 2'd3;

    // Microprogram step addresses.
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;
    localparam int UCODE_DEPTH = 1 << STEP_W;

    localparam step_t STEP_ACCEPT = 3'd0;
    localparam step_t STEP_COMP   = 3'd1;
    localparam step_t STEP_LENBLK = 3'd2;
    localparam step_t STEP_FINAL  = 3'd3;
    localparam step_t STEP_FROUND = 3'd4;
    localparam step_t STEP_EMIT   = 3'd5;

    // Source of the message block that is mixed into the lanes.
    typedef enum logic [1:0] {
        MIX_REG = 2'd0,
        MIX_IN  = 2'd1,
        MIX_LEN = 2'd2
    } mix_sel_t;

    // Source of the round count for the current step.
    typedef enum logic [1:0] {
        CNT_NONE  = 2'd0,
        CNT_REG   = 2'd1,
        CNT_COMP  = 2'd2,
        CNT_FINAL = 2'd3
    } cnt_src_t;

    // Sequencing condition of a control word.
    typedef enum logic [1:0] {
        COND_NEXT      = 2'd0,
        COND_LOOP      = 2'd1,
        COND_BLOCK_END = 2'd2
    } cond_t;

    typedef struct packed {
        logic     in_en;
        logic     emit;
        mix_sel_t mix_sel;
        logic     d_xor;
        logic     c_ff;
        logic     a_xor;
        cnt_src_t cnt_src;
        cond_t    cond;
        step_t    jmp;
        step_t    nxt;
    } uword_t;

    // The microprogram. Columns: in_en, emit, mix_sel, d_xor, c_ff, a_xor,
    // cnt_src, cond, jmp, nxt.
    localparam uword_t UCODE_ROM [UCODE_DEPTH] = '{
        '{1'b1, 1'b0, MIX_IN,  1'b1, 1'b0, 1'b1, CNT_COMP,  COND_BLOCK_END,
          STEP_COMP,   STEP_ACCEPT},
        '{1'b0, 1'b0, MIX_REG, 1'b0, 1'b0, 1'b1, CNT_REG,   COND_BLOCK_END,
          STEP_COMP,   STEP_ACCEPT},
        '{1'b0, 1'b0, MIX_LEN, 1'b1, 1'b0, 1'b1, CNT_COMP,  COND_BLOCK_END,
          STEP_COMP,   STEP_ACCEPT},
        '{1'b0, 1'b0, MIX_REG, 1'b0, 1'b1, 1'b0, CNT_FINAL, COND_LOOP,
          STEP_FROUND, STEP_EMIT},
        '{1'b0, 1'b0, MIX_REG, 1'b0, 1'b0, 1'b0, CNT_REG,   COND_LOOP,
          STEP_FROUND, STEP_EMIT},
        '{1'b0, 1'b1, MIX_REG, 1'b0, 1'b0, 1'b0, CNT_NONE,  COND_NEXT,
          STEP_ACCEPT, STEP_ACCEPT},
        '{1'b0, 1'b0, MIX_REG, 1'b0, 1'b0, 1'b0, CNT_NONE,  COND_NEXT,
          STEP_ACCEPT, STEP_ACCEPT},
        '{1'b0, 1'b0, MIX_REG, 1'b0, 1'b0, 1'b0, CNT_NONE,  COND_NEXT,
          STEP_ACCEPT, STEP_ACCEPT}
    };

    // Commands from the sequencer to the datapath, already qualified.
    typedef struct packed {
        logic     fire;
        logic     capture;
        logic     emit;
        mix_sel_t mix_sel;
        logic     d_xor;
        logic     c_ff;
        logic     round_en;
        logic     a_xor;
    } dp_cmd_t;

    // Flags from the datapath that steer the sequencer.
    typedef struct packed {
        logic last;
        logic pend;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } lanes_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
        return (v << n) | (v >> (64 - n));
    endfunction

    function automatic lanes_t sip_round(input lanes_t s);
        lanes_t r;
        r = s;
        r.a = r.a + r.b; r.b = rotl64(r.b, ROT_B1); r.b = r.b ^ r.a; r.a = rotl64(r.a, ROT_A);
        r.c = r.c + r.d; r.d = rotl64(r.d, ROT_D1); r.d = r.d ^ r.c;
        r.a = r.a + r.d; r.d = rotl64(r.d, ROT_D2); r.d = r.d ^ r.a;
        r.c = r.c + r.b; r.b = rotl64(r.b, ROT_B2); r.b = r.b ^ r.c; r.c = rotl64(r.c, ROT_A);
        return r;
    endfunction

    // Mask that keeps the low cnt bytes of a word.
    function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i*8 +: 8] = (4'(i) < cnt) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// File: rtl/siphash_keyed_hash.sv
// Throughput: one SipRound per cycle. Each word runs its compression rounds before the
// next word is taken; a full last word adds a block with only the length, and then the
// finalization rounds and the emit step follow, which waits while a held hash is not taken.
// The hash is registered, and out_valid raised, when the emit step fires.
// Reset (rst_n low, asynchronous): zero key, 2 and 4 rounds, lanes for the zero key, no result.
`timescale 1ns / 1ps

// Top level of the keyed SipHash block with a 64-bit result.
// Depends on shk_pkg, shk_sequencer and shk_datapath.
module siphash_keyed_hash
    import shk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port: key low, key high, compression and finalization rounds.
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // Message words.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] msg_word,
    input  logic [3:0]  byte_count,
    input  logic        last_word,
    // Hash results.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_value
);

    // The configuration registers live here. A write of either key half
    // reloads the lanes from the new key and clears the length count, so a
    // message in progress is dropped. A round count write takes effect at
    // the next block that starts its rounds.
    logic [63:0] key_low_reg, key_low_next;
    logic [63:0] key_high_reg, key_high_next;
    logic [3:0]  comp_rounds_reg, comp_rounds_next;
    logic [3:0]  final_rounds_reg, final_rounds_next;
    logic        key_reload;

    dp_cmd_t    cmd;
    dp_status_t status;

    always_comb
    begin
        key_low_next      = key_low_reg;
        key_high_next     = key_high_reg;
        comp_rounds_next  = comp_rounds_reg;
        final_rounds_next = final_rounds_reg;
        key_reload        = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:
                begin
                    key_low_next = cfg_data;
                    key_reload   = 1'b1;
                end
                CFG_KEY_HIGH:
                begin
                    key_high_next = cfg_data;
                    key_reload    = 1'b1;
                end
                CFG_COMP_ROUNDS:
                begin
                    comp_rounds_next = cfg_data[3:0];
                end
                CFG_FINAL_ROUNDS:
                begin
                    final_rounds_next = cfg_data[3:0];
                end
                default:
                begin
                    key_reload = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg      <= 64'd0;
            key_high_reg     <= 64'd0;
            comp_rounds_reg  <= RESET_COMP_ROUNDS;
            final_rounds_reg <= RESET_FINAL_ROUNDS;
        end
        else
        begin
            key_low_reg      <= key_low_next;
            key_high_reg     <= key_high_next;
            comp_rounds_reg  <= comp_rounds_next;
            final_rounds_reg <= final_rounds_next;
        end
    end

    // The sequencer walks the microprogram: the accept step takes a word,
    // mixes it into lane d and runs the first round in the same cycle; the
    // compression step loops on the round counter and then dispatches to the
    // next word, the length-only block (after a full last word) or the
    // finalization, which flips lane c, runs its rounds and emits the hash.
    shk_sequencer u_sequencer (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .comp_rounds  (comp_rounds_reg),
        .final_rounds (final_rounds_reg),
        .status       (status),
        .in_ready     (in_ready),
        .cmd          (cmd)
    );

    // The datapath holds the lanes and the result register. The emit step
    // waits only while an earlier hash is still held and not taken, so the
    // next message may be accepted while a result is pending.
    shk_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .msg_word   (msg_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .key_low    (key_low_next),
        .key_high   (key_high_next),
        .key_reload (key_reload),
        .out_ready  (out_ready),
        .status     (status),
        .out_valid  (out_valid),
        .hash_value (hash_value)
    );

endmodule

// File: rtl/shk_sequencer.sv
// Microcode sequencer: step counter, control table lookup, round counter
// and conditional jumps. Depends on shk_pkg.
`timescale 1ns / 1ps

module shk_sequencer
    import shk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [3:0] comp_rounds,
    input  logic [3:0] final_rounds,
    input  dp_status_t status,
    output logic       in_ready,
    output dp_cmd_t    cmd
);

    step_t      step_reg, step_next;
    logic [3:0] rc_reg, rc_next;
    uword_t     uw;
    logic [3:0] n_rounds;
    logic       has_rounds;
    logic       done;
    logic       fire;

    assign uw = UCODE_ROM[step_reg];

    always_comb
    begin
        unique case (uw.cnt_src)
            CNT_REG:   n_rounds = rc_reg;
            CNT_COMP:  n_rounds = comp_rounds;
            CNT_FINAL: n_rounds = final_rounds;
            default:   n_rounds = 4'd0;
        endcase
    end

    assign has_rounds = (uw.cnt_src != CNT_NONE);
    assign done       = (n_rounds <= 4'd1);
    assign fire       = uw.in_en ? in_valid : (uw.emit ? !status.out_busy : 1'b1);
    assign in_ready   = uw.in_en;

    always_comb
    begin
        cmd.fire     = fire;
        cmd.capture  = fire && uw.in_en;
        cmd.emit     = fire && uw.emit;
        cmd.mix_sel  = uw.mix_sel;
        cmd.d_xor    = fire && uw.d_xor;
        cmd.c_ff     = fire && uw.c_ff;
        cmd.round_en = fire && has_rounds && (n_rounds != 4'd0);
        cmd.a_xor    = fire && uw.a_xor && done;
    end

    always_comb
    begin
        step_next = step_reg;
        rc_next   = rc_reg;
        if (fire)
        begin
            if (has_rounds && !done)
            begin
                rc_next = n_rounds - 4'd1;
            end
            unique case (uw.cond)
                COND_NEXT:
                begin
                    step_next = uw.nxt;
                end
                COND_LOOP:
                begin
                    step_next = done ? uw.nxt : uw.jmp;
                end
                COND_BLOCK_END:
                begin
                    if (!done)
                    begin
                        step_next = uw.jmp;
                    end
                    else if (!status.last)
                    begin
                        step_next = STEP_ACCEPT;
                    end
                    else if (status.pend)
                    begin
                        step_next = STEP_LENBLK;
                    end
                    else
                    begin
                        step_next = STEP_FINAL;
                    end
                end
                default:
                begin
                    step_next = STEP_ACCEPT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_ACCEPT;
            rc_reg   <= 4'd0;
        end
        else
        begin
            step_reg <= step_next;
            rc_reg   <= rc_next;
        end
    end

endmodule

// File: rtl/shk_datapath.sv
// Datapath: the four lanes with one SipRound unit, block forming, length
// count and the result register. Depends on shk_pkg.
`timescale 1ns / 1ps

module shk_datapath
    import shk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [63:0] msg_word,
    input  logic [3:0]  byte_count,
    input  logic        last_word,
    input  logic [63:0] key_low,
    input  logic [63:0] key_high,
    input  logic        key_reload,
    input  logic        out_ready,
    output dp_status_t  status,
    output logic        out_valid,
    output logic [63:0] hash_value
);

    lanes_t      lanes_reg;
    lanes_t      pre, rnd, post, key_lanes;
    logic [7:0]  len_reg;
    logic [7:0]  len_inc, len_new;
    logic [63:0] m_reg, m_cur, blk_in, blk_len;
    logic        last_reg, pend_reg, out_valid_reg;
    logic [63:0] hash_reg;
    logic [3:0]  cnt_sat;
    logic        full;

    // Byte counts above eight count as a full word.
    assign cnt_sat = (byte_count > BYTES_PER_WORD) ? BYTES_PER_WORD : byte_count;
    assign full    = (cnt_sat == BYTES_PER_WORD);
    assign len_inc = last_word ? {4'd0, cnt_sat} : {4'd0, BYTES_PER_WORD};
    assign len_new = len_reg + len_inc;

    // A short last word carries the updated length in its top byte.
    assign blk_in  = (last_word && !full) ?
                     ((msg_word & byte_mask(cnt_sat)) | {len_new, 56'd0}) : msg_word;
    assign blk_len = {len_reg, 56'd0};

    always_comb
    begin
        case (cmd.mix_sel)
            MIX_IN:  m_cur = blk_in;
            MIX_LEN: m_cur = blk_len;
            default: m_cur = m_reg;
        endcase
    end

    always_comb
    begin
        pre = lanes_reg;
        if (cmd.d_xor)
        begin
            pre.d = pre.d ^ m_cur;
        end
        if (cmd.c_ff)
        begin
            pre.c = pre.c ^ {56'd0, FIN_XOR};
        end
        rnd  = cmd.round_en ? sip_round(pre) : pre;
        post = rnd;
        if (cmd.a_xor)
        begin
            post.a = post.a ^ m_cur;
        end
    end

    assign key_lanes = '{a: key_low ^ INIT_A, b: key_high ^ INIT_B,
                         c: key_low ^ INIT_C, d: key_high ^ INIT_D};

    always_comb
    begin
        status.last     = (cmd.mix_sel == MIX_IN) ? last_word : last_reg;
        status.pend     = (cmd.mix_sel == MIX_IN)  ? (last_word && full) :
                          (cmd.mix_sel == MIX_LEN) ? 1'b0 : pend_reg;
        status.out_busy = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_reg     <= '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
            len_reg       <= 8'd0;
            last_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (key_reload || cmd.emit)
            begin
                lanes_reg <= key_lanes;
                len_reg   <= 8'd0;
            end
            else
            begin
                if (cmd.fire)
                begin
                    lanes_reg <= post;
                end
                if (cmd.capture)
                begin
                    len_reg <= len_new;
                end
            end
            if (cmd.capture)
            begin
                last_reg <= last_word;
                pend_reg <= last_word && full;
            end
            else if (cmd.fire && (cmd.mix_sel == MIX_LEN))
            begin
                pend_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            m_reg <= m_cur;
        end
        if (cmd.emit)
        begin
            hash_reg <= lanes_reg.a ^ lanes_reg.b ^ lanes_reg.c ^ lanes_reg.d;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

// File: rtl/shk_checker.sv
// Port-level checker for the keyed SipHash block, bound to the top level.
// Depends on siphash_keyed_hash_assert.svh and siphash_keyed_hash.
`timescale 1ns / 1ps
`include "siphash_keyed_hash_assert.svh"

module shk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last_word,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] hash_value
);

    // A held result keeps its value until it is taken.
    `SHK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hash_value), "result changed while stalled")

    // A word that is not the last one never produces a result.
    `SHK_ASSERT_NEXT(a_no_mid_result, in_valid && in_ready && !last_word && !out_valid, !out_valid, "result after a non-last word")

    // After the last word the block is busy finishing the hash.
    `SHK_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && last_word, !in_ready, "word accepted right after a last word")

    // Emitting a hash returns the sequencer to the accept step.
    `SHK_ASSERT_NOW(a_result_frees_input, $rose(out_valid), in_ready, "input not ready after a result")

endmodule

bind siphash_keyed_hash shk_checker u_shk_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
);

// File: tb/siphash_hash_checker.sv
// Checker for the keyed SipHash block: watches the register port and both word
// channels, predicts every hash and compares it with what the block emits.
// Depends on shk_pkg for the register indexes.
`timescale 1ns / 1ps

module siphash_hash_checker
    import shk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] msg_word,
    input  logic [3:0]  byte_count,
    input  logic        last_word,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] hash_value,
    output int          mismatches,
    output int          hashes_outstanding,
    output int          hashes_matched
);

    localparam logic [63:0] IV0 = 64'h736F6D6570736575;
    localparam logic [63:0] IV1 = 64'h646F72616E646F6D;
    localparam logic [63:0] IV2 = 64'h6C7967656E657261;
    localparam logic [63:0] IV3 = 64'h7465646279746573;
    localparam logic [3:0]  FULL_WORD_BYTES = 4'd8;

    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [3:0]  comp_n;
    logic [3:0]  fin_n;
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
    logic [7:0]  msg_len;
    logic [63:0] hash_due_q[$];

    function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    task automatic sip_rounds(input logic [3:0] n);
        for (int r = 0; r < n; r++) begin
            v0 = v0 + v1; v1 = rotl(v1, 13); v1 = v1 ^ v0; v0 = rotl(v0, 32);
            v2 = v2 + v3; v3 = rotl(v3, 16); v3 = v3 ^ v2;
            v0 = v0 + v3; v3 = rotl(v3, 21); v3 = v3 ^ v0;
            v2 = v2 + v1; v1 = rotl(v1, 17); v1 = v1 ^ v2; v2 = rotl(v2, 32);
        end
    endtask

    task automatic compress(input logic [63:0] m);
        v3 = v3 ^ m;
        sip_rounds(comp_n);
        v0 = v0 ^ m;
    endtask

    task automatic load_key_state();
        v0 = key_lo ^ IV0;
        v1 = key_hi ^ IV1;
        v2 = key_lo ^ IV2;
        v3 = key_hi ^ IV3;
        msg_len = 8'd0;
    endtask

    // Folds one accepted word into the state; a last word queues the hash it yields.
    task automatic fold_word(input logic [63:0] w, input logic [3:0] n_in, input logic is_last);
        logic [3:0]  n;
        logic [63:0] tail;
        n = (n_in > FULL_WORD_BYTES) ? FULL_WORD_BYTES : n_in;
        if (!is_last) begin
            compress(w);
            msg_len = msg_len + 8'd8;
        end
        else begin
            msg_len = msg_len + 8'(n);
            tail = 64'd0;
            if (n == FULL_WORD_BYTES) begin
                compress(w);
            end
            else begin
                for (int b = 0; b < n; b++) begin
                    tail[8*b +: 8] = w[8*b +: 8];
                end
            end
            tail[63:56] = msg_len;
            compress(tail);
            v2 = v2 ^ 64'hFF;
            sip_rounds(fin_n);
            hash_due_q.push_back(v0 ^ v1 ^ v2 ^ v3);
            load_key_state();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : hash_tracking
        logic [63:0] want;
        if (!rst_n) begin
            key_lo = 64'd0;
            key_hi = 64'd0;
            comp_n = 4'd2;
            fin_n  = 4'd4;
            load_key_state();
            hash_due_q.delete();
            mismatches     <= 0;
            hashes_matched <= 0;
        end
        else begin
            // Results leave before this edge's word is folded in; a new word
            // cannot produce a hash at the edge that accepts it.
            if (out_valid && out_ready) begin
                if (hash_due_q.size() == 0) begin
                    $display("%0t: unexpected hash, expected none, got %h", $time, hash_value);
                    mismatches <= mismatches + 1;
                end
                else begin
                    want = hash_due_q.pop_front();
                    if (hash_value !== want) begin
                        $display("%0t: hash mismatch, expected %h, got %h",
                                 $time, want, hash_value);
                        mismatches <= mismatches + 1;
                    end
                    else begin
                        hashes_matched <= hashes_matched + 1;
                    end
                end
            end
            if (cfg_write) begin
                case (cfg_index)
                    CFG_KEY_LOW:
                    begin
                        key_lo = cfg_data;
                        load_key_state();
                    end
                    CFG_KEY_HIGH:
                    begin
                        key_hi = cfg_data;
                        load_key_state();
                    end
                    CFG_COMP_ROUNDS:  comp_n = cfg_data[3:0];
                    CFG_FINAL_ROUNDS: fin_n  = cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready) begin
                fold_word(msg_word, byte_count, last_word);
            end
        end
        hashes_outstanding <= hash_due_q.size();
    end

endmodule

// File: tb/siphash_keyed_hash_tb.sv
// Top of the keyed SipHash testbench: drives messages, register writes and
// output stalls, and gives the verdict. Depends on shk_pkg, the block and siphash_hash_checker.
`timescale 1ns / 1ps

module siphash_keyed_hash_tb;
    import shk_pkg::*;

    // Words per random phase; six phases give about 450 words in total.
    localparam int WORDS_PER_PHASE = 75;
    localparam int NUM_PHASES      = 6;
    // This pause is long enough for the slowest word (15 compression rounds,
    // full last word, 15 final rounds) to finish, so the block goes idle.
    localparam int SETTLE_CYCLES   = 60;
    // The one long receiver hold-off that backs the block up.
    localparam int RX_HOLD_CYCLES  = 400;
    // Cycles without any accepted word before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 4000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_write  = 1'b0;
    logic [1:0]  cfg_index  = CFG_KEY_LOW;
    logic [63:0] cfg_data   = 64'd0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [63:0] msg_word   = 64'd0;
    logic [3:0]  byte_count = 4'd0;
    logic        last_word  = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [63:0] hash_value;

    int mismatches;
    int hashes_outstanding;
    int hashes_matched;

    // Set for a message at a time to run both sides without any gaps.
    bit steady      = 1'b0;
    // Raised once by the stimulus to ask the receiver for its long hold-off.
    bit rx_hold_req = 1'b0;

    int words_sent       = 0;
    int messages_sent    = 0;
    int settings_applied = 0;
    int idle_cycles      = 0;

    siphash_keyed_hash uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .msg_word   (msg_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    siphash_hash_checker hash_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .msg_word           (msg_word),
        .byte_count         (byte_count),
        .last_word          (last_word),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .hash_value         (hash_value),
        .mismatches         (mismatches),
        .hashes_outstanding (hashes_outstanding),
        .hashes_matched     (hashes_matched)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offers one word after an optional gap and returns just after the edge
    // that accepts it. Valid is only lowered when a gap is actually taken, so
    // back-to-back words keep it high without a second assignment in the step.
    task automatic send_word(input logic [63:0] w, input logic [3:0] n, input logic is_last);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        msg_word   <= w;
        byte_count <= n;
        last_word  <= is_last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        if (is_last) begin
            messages_sent++;
        end
    endtask

    // Stops offering words, waits for every predicted hash to be taken, then
    // gives the block time to finish a word that yields no hash. The first
    // edge lets the checker's count catch up with the last accepted word.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (hashes_outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Holds the write enable high for one edge; the caller lowers it after the
    // last write of a group so that it never drops and rises in the same step.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Writes all four registers. The round counts take only the low four bits,
    // so the upper data bits are filled with noise that must be ignored.
    task automatic set_config(input logic [63:0] kl, input logic [63:0] kh,
                              input logic [3:0] cr, input logic [3:0] fr);
        write_reg(CFG_KEY_LOW, kl);
        write_reg(CFG_KEY_HIGH, kh);
        write_reg(CFG_COMP_ROUNDS, {$urandom, 28'($urandom), cr});
        write_reg(CFG_FINAL_ROUNDS, {$urandom, 28'($urandom), fr});
        cfg_write <= 1'b0;
        settings_applied++;
    endtask

    // One well-formed message with random content. Most are short; a few run
    // past 256 bytes so the length byte wraps. Non-last words sometimes carry a
    // byte count other than 8, and last words sometimes one above 8.
    task automatic send_message();
        int r;
        int n_words;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            n_words = 1;
        end
        else if (r < 85) begin
            n_words = $urandom_range(2, 6);
        end
        else if (r < 97) begin
            n_words = $urandom_range(7, 12);
        end
        else begin
            n_words = $urandom_range(30, 40);
        end
        steady = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < n_words - 1; i++) begin
            send_word(rand64(), ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8,
                      1'b0);
        end
        send_word(rand64(),
                  ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 8)),
                  1'b1);
    endtask

    // Receiver: takes hashes with random stalls, runs without stalls while the
    // stimulus asks for a steady stretch, and once holds off for a long time.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left  = RX_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (steady || $urandom_range(0, 3) != 0) begin
                out_ready <= 1'b1;
            end
            else begin
                out_ready  <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // Watchdog: any accepted word on either channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int phase_start;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset settings: zero key, 2 and 4 rounds.
        // An empty message is only the length block.
        send_word(64'd0, 4'd0, 1'b1);
        // A full last word is compressed whole, then a block with only the length.
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        // Short last words: the bytes above the count must be masked off.
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 4'd3, 1'b1);
        send_word(64'h5555_5555_5555_5555, 4'd7, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
        // Counts above 8 on a last word behave as 8.
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b1);
        send_word(64'h0123_4567_89AB_CDEF, 4'd15, 1'b1);
        // Non-last words count as full 8-byte words whatever their byte count.
        send_word(64'd0, 4'd8, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
        send_word(64'hFEDC_BA98_7654_3210, 4'd15, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd5, 1'b1);

        // A key write in the middle of a message throws that message away and
        // starts over from the new key.
        send_word(rand64(), 4'd8, 1'b0);
        send_word(rand64(), 4'd8, 1'b0);
        settle();
        write_reg(CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write <= 1'b0;
        send_word(rand64(), 4'd4, 1'b1);

        // A round count written in the middle of a message applies to the
        // blocks that follow and leaves the message intact.
        send_word(rand64(), 4'd8, 1'b0);
        settle();
        write_reg(CFG_COMP_ROUNDS, 64'd3);
        cfg_write <= 1'b0;
        send_word(rand64(), 4'd8, 1'b1);
        send_word(rand64(), 4'd6, 1'b1);
        settle();

        // Random phases, each with its own register setting, extremes included.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_config(rand64(), rand64(), 4'd2, 4'd4);
                1: set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 4'd1);
                2: set_config(rand64(), rand64(), 4'd8, 4'd8);
                3: set_config(rand64(), rand64(), 4'd0, 4'd0);
                4: set_config(64'd0, 64'd0, 4'd15, 4'd15);
                default: set_config(rand64(), rand64(), 4'($urandom_range(0, 15)),
                                    4'($urandom_range(0, 15)));
            endcase
            // With one round per block the block is fast, so a long receiver
            // stall here quickly fills it and pushes back on the input.
            if (ph == 1) begin
                rx_hold_req = 1'b1;
            end
            phase_start = words_sent;
            while (words_sent - phase_start < WORDS_PER_PHASE) begin
                send_message();
            end
            settle();
        end

        $display("Sent %0d words in %0d messages under %0d register settings;",
                 words_sent, messages_sent, settings_applied + 1);
        $display("%0d hashes checked, %0d mismatches.", hashes_matched, mismatches);
        if (mismatches == 0 && hashes_outstanding == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
